>>> design/orb_pkg.sv
// ----------------------------------------------------------------------------
// orb_pkg: shared types and constants of the overwriting record ring buffer
// Holds the word field widths, command kinds, register indexes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

  localparam int KIND_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 8;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LOG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN   = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_VOICE  = 3'd2,
    KIND_COMMIT = 3'd3,
    KIND_QUERY  = 3'd4,
    KIND_READ   = 3'd5,
    KIND_CLEAR  = 3'd6,
    KIND_NOP    = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADDR,
    S_EXEC,
    S_TERM,
    S_CSTART,
    S_COUNT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_cmd;
    logic decode;
    logic addr_calc;
    logic exec;
    logic term;
    logic count_start;
    logic clear_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic count_busy;
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> design/orb_if.sv
// ----------------------------------------------------------------------------
// orb_if: channel interfaces of the overwriting record ring buffer
// Command, response and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface orb_cmd_if import orb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  data_byte;
  logic [INDEX_W-1:0] entry_index;
  logic [INDEX_W-1:0] byte_offset;

  modport source (output valid, kind, data_byte, entry_index, byte_offset, input ready);
  modport sink   (input valid, kind, data_byte, entry_index, byte_offset, output ready);
endinterface

interface orb_rsp_if import orb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  record_address;
  logic               voice_mark;
  logic [COUNT_W-1:0] record_count;
  logic [BYTE_W-1:0]  byte_value;
  logic               overflow;
  logic               recording;

  modport source (output valid, record_address, voice_mark, record_count, byte_value,
                  overflow, recording, input ready);
  modport sink   (input valid, record_address, voice_mark, record_count, byte_value,
                  overflow, recording, output ready);
endinterface

interface orb_cfg_if import orb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

>>> design/orb_ram.sv
// ----------------------------------------------------------------------------
// orb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/orb_ctrl.sv
// ----------------------------------------------------------------------------
// orb_ctrl: sequencing controller of the record ring buffer
// Walks each command through decode, address, execute, terminator (none for
// a clear), count and response steps, and runs the byte store clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ctrl import orb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       ctl
);

  state_t state, state_next;
  logic   reply, reply_next;
  logic   out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      reply     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      reply     <= reply_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    reply_next = reply;
    ctl        = '0;
    cmd_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (status.clear_last) begin
          // After reset nobody waits for a word; after a clear command one does.
          state_next = reply ? S_CSTART : S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.load_cmd = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.decode = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        ctl.addr_calc = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (status.is_clear) begin
          reply_next = 1'b1;
          state_next = S_CLEAR;
        end else begin
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        ctl.term   = 1'b1;
        state_next = S_CSTART;
      end
      S_CSTART: begin
        ctl.count_start = 1'b1;
        state_next      = S_COUNT;
      end
      S_COUNT: begin
        if (!status.count_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp_ready) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign rsp_valid = out_valid;

endmodule

`default_nettype wire

>>> design/orb_dpath.sv
// ----------------------------------------------------------------------------
// orb_dpath: datapath of the record ring buffer
// Ring pointers, present and voice marks, fill-level and byte stores,
// address arithmetic, the present-record walk and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_dpath import orb_pkg::*; #(
  parameter int ENTRIES      = 16,
  parameter int RECORD_BYTES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_cmd_t             ctl,
  output dp_status_t                 status,
  input  wire logic [KIND_W-1:0]     kind_in,
  input  wire logic [BYTE_W-1:0]     data_in,
  input  wire logic [INDEX_W-1:0]    index_in,
  input  wire logic [INDEX_W-1:0]    offset_in,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic      [ADDR_W-1:0]     out_address,
  output logic                       out_voice,
  output logic      [COUNT_W-1:0]    out_count,
  output logic      [BYTE_W-1:0]     out_byte,
  output logic                       out_overflow,
  output logic                       out_recording
);

  localparam int DEPTH = ENTRIES * RECORD_BYTES;
  localparam int SW    = $clog2(ENTRIES);
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(RECORD_BYTES + 1);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int IW    = ((SW > INDEX_W) ? SW : INDEX_W) + 1;
  localparam int OW    = ((FW > INDEX_W) ? FW : INDEX_W) + 1;
  localparam int CXW   = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [AW-1:0] RB_A      = AW'(RECORD_BYTES);
  localparam logic [SW-1:0] LAST_SLOT = SW'(ENTRIES - 1);

  // Command word and configuration
  kind_t              kind_q;
  logic [BYTE_W-1:0]  data_q;
  logic [INDEX_W-1:0] idx_q;
  logic [INDEX_W-1:0] off_q;
  logic               log_enable;
  logic [ADDR_W-1:0]  base_address;

  // Ring state
  logic [ENTRIES-1:0] present;
  logic [ENTRIES-1:0] voice;
  logic [SW-1:0]      head;
  logic [SW-1:0]      tail;
  logic               ring_empty;
  logic               open_flag;

  // Per-command working registers
  logic [SW-1:0]      slot_q;
  logic               idx_ok;
  logic               off_ok;
  logic [FW-1:0]      fill_q;
  logic [AW-1:0]      slot_base;
  logic [AW-1:0]      mem_addr;
  logic               term_q;
  logic [ADDR_W-1:0]  res_addr;
  logic               res_voice;
  logic [BYTE_W-1:0]  res_byte;
  logic               res_ovf;

  // Present-record walk and clearing pass
  logic [CW-1:0]      cnt;
  logic [SW-1:0]      walk_ptr;
  logic               count_busy;
  logic [AW-1:0]      clr_cnt;
  logic               clear_last;

  // Store ports
  logic               fill_we;
  logic [SW-1:0]      fill_wa;
  logic [FW-1:0]      fill_wd;
  logic [FW-1:0]      fill_rd;
  logic               byte_we;
  logic [AW-1:0]      byte_wa;
  logic [BYTE_W-1:0]  byte_wd;
  logic               byte_re;
  logic [BYTE_W-1:0]  byte_rd;

  logic [IW-1:0]      slot_sum;
  logic [IW-1:0]      slot_mod;
  logic [FW-1:0]      fill_inc;
  logic [CXW-1:0]     cnt_ext;
  logic               open_ok;
  logic               commit_ok;
  logic               append_ok;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  assign slot_sum   = IW'(tail) + IW'(idx_q);
  assign slot_mod   = (slot_sum >= IW'(ENTRIES)) ? slot_sum - IW'(ENTRIES) : slot_sum;
  assign fill_inc   = fill_q + FW'(1);
  assign cnt_ext    = CXW'(cnt);
  assign clear_last = (clr_cnt == AW'(DEPTH - 1));
  assign open_ok    = log_enable && !open_flag;
  assign commit_ok  = log_enable && open_flag;
  assign append_ok  = (fill_q < FW'(RECORD_BYTES));

  assign status.is_clear   = (kind_q == KIND_CLEAR);
  assign status.count_busy = count_busy;
  assign status.clear_last = clear_last;

  // Store write and read selection
  always_comb begin
    fill_we = 1'b0;
    fill_wa = head;
    fill_wd = '0;
    byte_we = 1'b0;
    byte_wa = mem_addr;
    byte_wd = data_q;
    byte_re = 1'b0;
    if (ctl.clear_step) begin
      byte_we = 1'b1;
      byte_wa = clr_cnt;
      byte_wd = '0;
      fill_we = (clr_cnt < AW'(ENTRIES));
      fill_wa = SW'(clr_cnt);
    end else if (ctl.exec) begin
      case (kind_q)
        KIND_OPEN: begin
          fill_we = open_ok;
        end
        KIND_APPEND: begin
          fill_we = append_ok;
          fill_wd = fill_inc;
          byte_we = append_ok;
        end
        KIND_READ: begin
          byte_re = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (ctl.term) begin
      // Zero terminator behind the new byte, only while still inside the record.
      byte_we = (kind_q == KIND_APPEND) && term_q;
      byte_wa = mem_addr + AW'(1);
      byte_wd = '0;
    end
  end

  orb_ram #(.WIDTH(FW), .DEPTH(ENTRIES)) u_fill_ram (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_wa),
    .wr_data (fill_wd),
    .rd_en   (ctl.decode),
    .rd_addr (head),
    .rd_data (fill_rd)
  );

  orb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_we),
    .wr_addr (byte_wa),
    .wr_data (byte_wd),
    .rd_en   (byte_re),
    .rd_addr (mem_addr),
    .rd_data (byte_rd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      log_enable   <= 1'b0;
      base_address <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOG_ENABLE:   log_enable   <= cfg_data[0];
        REG_BASE_ADDRESS: base_address <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Ring state, walk and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      voice      <= '0;
      head       <= '0;
      tail       <= '0;
      ring_empty <= 1'b1;
      open_flag  <= 1'b0;
      count_busy <= 1'b0;
      cnt        <= '0;
      walk_ptr   <= '0;
      clr_cnt    <= '0;
    end else begin
      if (ctl.clear_step) begin
        clr_cnt <= clear_last ? '0 : clr_cnt + AW'(1);
      end
      if (ctl.exec) begin
        case (kind_q)
          KIND_OPEN: begin
            if (open_ok) begin
              if (head == tail && !ring_empty) begin
                tail <= next_slot(tail);
              end
              present[head] <= 1'b0;
              voice[head]   <= 1'b0;
              open_flag     <= 1'b1;
            end
          end
          KIND_VOICE: begin
            voice[head] <= 1'b1;
          end
          KIND_COMMIT: begin
            if (commit_ok) begin
              present[head] <= 1'b1;
              head          <= next_slot(head);
              ring_empty    <= 1'b0;
              open_flag     <= 1'b0;
            end
          end
          KIND_CLEAR: begin
            present    <= '0;
            voice      <= '0;
            head       <= '0;
            tail       <= '0;
            ring_empty <= 1'b1;
            clr_cnt    <= '0;
          end
          default: begin
          end
        endcase
      end
      // Count the run of present records starting at the tail, one per cycle.
      if (ctl.count_start) begin
        if (ring_empty || !present[tail]) begin
          cnt        <= '0;
          count_busy <= 1'b0;
        end else begin
          cnt        <= CW'(1);
          walk_ptr   <= next_slot(tail);
          count_busy <= 1'b1;
        end
      end else if (count_busy) begin
        if (walk_ptr != tail && present[walk_ptr]) begin
          cnt      <= cnt + CW'(1);
          walk_ptr <= next_slot(walk_ptr);
        end else begin
          count_busy <= 1'b0;
        end
      end
    end
  end

  // Command word and result payload
  always_ff @(posedge clk) begin
    if (ctl.load_cmd) begin
      kind_q    <= kind_t'(kind_in);
      data_q    <= data_in;
      idx_q     <= index_in;
      off_q     <= offset_in;
      res_addr  <= '0;
      res_voice <= 1'b0;
      res_byte  <= '0;
      res_ovf   <= 1'b0;
      term_q    <= 1'b0;
    end
    if (ctl.decode) begin
      slot_q <= SW'(slot_mod);
      idx_ok <= (IW'(idx_q) < IW'(ENTRIES));
      off_ok <= (OW'(off_q) < OW'(RECORD_BYTES));
    end
    if (ctl.addr_calc) begin
      fill_q    <= fill_rd;
      slot_base <= AW'(slot_q) * RB_A;
      if (kind_q == KIND_APPEND) begin
        mem_addr <= AW'(head) * RB_A + AW'(fill_rd);
      end else begin
        mem_addr <= AW'(slot_q) * RB_A + AW'(off_q);
      end
    end
    if (ctl.exec) begin
      case (kind_q)
        KIND_APPEND: begin
          res_ovf <= !append_ok;
          term_q  <= append_ok && (fill_inc < FW'(RECORD_BYTES));
        end
        KIND_QUERY: begin
          if (idx_ok && present[slot_q]) begin
            res_addr  <= base_address + ADDR_W'(slot_base);
            res_voice <= voice[slot_q];
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl.term && kind_q == KIND_READ) begin
      res_byte <= (idx_ok && off_ok) ? byte_rd : '0;
    end
    if (ctl.load_out) begin
      out_address   <= res_addr;
      out_voice     <= res_voice;
      out_count     <= cnt_ext[COUNT_W-1:0];
      out_byte      <= res_byte;
      out_overflow  <= res_ovf;
      out_recording <= open_flag;
    end
  end

endmodule

`default_nettype wire

>>> design/overwriting_record_ring_buffer.sv
// ----------------------------------------------------------------------------
// overwriting_record_ring_buffer: ring of fixed-size byte records
// Commands arrive on the cmd channel, one response word per command leaves on
// the rsp channel, and two registers are written over the cfg channel.
//
// After acceptance a command passes the decode, address, execute, terminator
// and count-start steps and then the count walk, which steps through the
// present marks from the tail one slot a cycle, before its response register
// is loaded; the next command is taken only after that load.
// A clear command skips the terminator step and runs a clearing pass that
// zeroes the byte store and fill levels, one byte a cycle; its response is
// loaded after the pass and the count steps. The same pass runs after reset;
// cmd is not ready during it, while cfg writes are always taken.
// A response waits in an output register; while the receiver stalls, the
// next command is still accepted and processed, and its response is held
// until the register is free. Reset clears the ring, the recording flag and
// both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_record_ring_buffer import orb_pkg::*; #(
  parameter int ENTRIES      = 16,
  parameter int RECORD_BYTES = 256
) (
  input wire logic  clk,
  input wire logic  rst,
  orb_cmd_if.sink   cmd,
  orb_rsp_if.source rsp,
  orb_cfg_if.sink   cfg
);

  ctrl_cmd_t  ctl;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  orb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .ctl       (ctl)
  );

  orb_dpath #(
    .ENTRIES      (ENTRIES),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .status        (status),
    .kind_in       (cmd.kind),
    .data_in       (cmd.data_byte),
    .index_in      (cmd.entry_index),
    .offset_in     (cmd.byte_offset),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.reg_index),
    .cfg_data      (cfg.write_data),
    .out_address   (rsp.record_address),
    .out_voice     (rsp.voice_mark),
    .out_count     (rsp.record_count),
    .out_byte      (rsp.byte_value),
    .out_overflow  (rsp.overflow),
    .out_recording (rsp.recording)
  );

endmodule

`default_nettype wire

>>> tb/sv/orb_checker.sv
// ----------------------------------------------------------------------------
// orb_checker: response checker for the overwriting record ring buffer
// Watches the command, response and register channels, keeps its own copy of
// the ring state, predicts one response word per accepted command and checks
// every accepted response word against the oldest prediction.
// ----------------------------------------------------------------------------
module orb_checker import orb_pkg::*; #(
  parameter int ENTRIES      = 16,
  parameter int RECORD_BYTES = 256
) (
  input  logic clk,
  input  logic rst,
  orb_cmd_if   cmd,
  orb_rsp_if   rsp,
  orb_cfg_if   cfg,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic               voice;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  value;
    logic               ovf;
    logic               rec;
  } ring_response_t;

  logic              log_enable;
  logic [ADDR_W-1:0] base_address;
  logic              present_mark [ENTRIES];
  logic              voice_mark [ENTRIES];
  int unsigned       fill_level [ENTRIES];
  logic [BYTE_W-1:0] store [ENTRIES*RECORD_BYTES];
  int unsigned       head_slot;
  int unsigned       tail_slot;
  bit                ring_empty;
  bit                record_open;

  ring_response_t expected_responses [$];
  int             errors = 0;
  int             words_seen = 0;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic void clear_ring();
    for (int s = 0; s < ENTRIES; s++) begin
      present_mark[s] = 1'b0;
      voice_mark[s]   = 1'b0;
      fill_level[s]   = 0;
    end
    for (int b = 0; b < ENTRIES*RECORD_BYTES; b++) store[b] = '0;
    head_slot  = 0;
    tail_slot  = 0;
    ring_empty = 1'b1;
  endfunction

  // Walks forward from the oldest slot and stops at the first gap.
  function automatic int unsigned count_present();
    int unsigned n;
    int unsigned s;
    n = 0;
    s = tail_slot;
    if (ring_empty || !present_mark[tail_slot]) return 0;
    do begin
      n++;
      s = (s + 1) % ENTRIES;
    end while (s != tail_slot && present_mark[s]);
    return n;
  endfunction

  function automatic ring_response_t predict_response(kind_t k, logic [7:0] data,
                                                      logic [7:0] idx, logic [7:0] off);
    ring_response_t r;
    int unsigned    slot;
    int unsigned    f;
    int unsigned    start;
    bit             idx_ok;
    r      = '0;
    r.kind = k;
    idx_ok = idx < ENTRIES;
    slot   = idx_ok ? (tail_slot + idx) % ENTRIES : 0;
    start  = head_slot * RECORD_BYTES;
    case (k)
      KIND_OPEN: begin
        if (log_enable && !record_open) begin
          // A full ring drops its oldest record to make room.
          if (head_slot == tail_slot && !ring_empty) tail_slot = (tail_slot + 1) % ENTRIES;
          fill_level[head_slot]   = 0;
          present_mark[head_slot] = 1'b0;
          voice_mark[head_slot]   = 1'b0;
          record_open             = 1'b1;
        end
      end
      KIND_APPEND: begin
        f = fill_level[head_slot];
        if (f >= RECORD_BYTES) begin
          r.ovf = 1'b1;
        end else begin
          store[start + f] = data;
          f++;
          fill_level[head_slot] = f;
          if (f < RECORD_BYTES) store[start + f] = '0;
        end
      end
      KIND_VOICE: voice_mark[head_slot] = 1'b1;
      KIND_COMMIT: begin
        if (log_enable && record_open) begin
          present_mark[head_slot] = 1'b1;
          head_slot               = (head_slot + 1) % ENTRIES;
          ring_empty              = 1'b0;
          record_open             = 1'b0;
        end
      end
      KIND_QUERY: begin
        if (idx_ok && present_mark[slot]) begin
          r.addr  = base_address + ADDR_W'(slot * RECORD_BYTES);
          r.voice = voice_mark[slot];
        end
      end
      KIND_READ: begin
        if (idx_ok && off < RECORD_BYTES) r.value = store[slot * RECORD_BYTES + off];
      end
      KIND_CLEAR: clear_ring();
      default: ;
    endcase
    r.count = COUNT_W'(count_present());
    r.rec   = record_open;
    return r;
  endfunction

  function automatic string describe(ring_response_t r);
    return $sformatf("addr=%h voice=%0d count=%0d byte=%h ovf=%0d rec=%0d",
                     r.addr, r.voice, r.count, r.value, r.ovf, r.rec);
  endfunction

  always @(posedge clk) begin : watch
    ring_response_t seen;
    ring_response_t want;
    if (rst) begin
      clear_ring();
      record_open  = 1'b0;
      log_enable   = 1'b0;
      base_address = '0;
      expected_responses.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.reg_index == REG_LOG_ENABLE) log_enable = cfg.write_data[0];
        else if (cfg.reg_index == REG_BASE_ADDRESS) base_address = cfg.write_data;
      end
      // Responses are checked before new predictions so that an empty queue
      // is never satisfied by a command accepted on the same edge.
      if (rsp.valid && rsp.ready) begin
        words_seen++;
        seen.addr  = rsp.record_address;
        seen.voice = rsp.voice_mark;
        seen.count = rsp.record_count;
        seen.value = rsp.byte_value;
        seen.ovf   = rsp.overflow;
        seen.rec   = rsp.recording;
        if (expected_responses.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("word %0d arrived with no command outstanding: %s", words_seen,
                     describe(seen));
        end else begin
          want      = expected_responses.pop_front();
          seen.kind = want.kind;
          if (seen.addr !== want.addr || seen.voice !== want.voice ||
              seen.count !== want.count || seen.value !== want.value ||
              seen.ovf !== want.ovf || seen.rec !== want.rec) begin
            errors++;
            if (errors <= 10)
              $display("word %0d (%s) mismatch: expected %s, got %s", words_seen,
                       want.kind.name(), describe(want), describe(seen));
          end
        end
      end
      if (cmd.valid && cmd.ready)
        expected_responses.push_back(predict_response(kind_t'(cmd.kind), cmd.data_byte,
                                                      cmd.entry_index, cmd.byte_offset));
    end
    mismatch_count <= errors;
    outstanding    <= expected_responses.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the overwriting record ring buffer
// Drives commands in random bursts under several register settings, stalls
// the response side on changing patterns with one long hold-off, and reports
// the verdict from the failure count of the response checker.
// ----------------------------------------------------------------------------
module tb_top;
  import orb_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int RECORD_BYTES = 256;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   outstanding;
  int   words_sent = 0;
  int   burst_left = 1;
  bit   long_hold_done = 1'b0;

  orb_cmd_if cmd ();
  orb_rsp_if rsp ();
  orb_cfg_if cfg ();

  overwriting_record_ring_buffer #(
    .ENTRIES      (ENTRIES),
    .RECORD_BYTES (RECORD_BYTES)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .cfg (cfg)
  );

  orb_checker #(
    .ENTRIES      (ENTRIES),
    .RECORD_BYTES (RECORD_BYTES)
  ) ring_watch (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rsp            (rsp),
    .cfg            (cfg),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_burst();
    if ($urandom_range(0, 5) == 0) return $urandom_range(40, 100);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 17));
  endfunction

  function automatic logic [7:0] pick_offset();
    if ($urandom_range(0, 5) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 15));
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is
  // taken. Valid stays high inside a burst so back-to-back words need no gap.
  task automatic send_word(input kind_t k, input logic [7:0] data, input logic [7:0] idx,
                           input logic [7:0] off);
    cmd.kind        = k;
    cmd.data_byte   = data;
    cmd.entry_index = idx;
    cmd.byte_offset = off;
    cmd.valid       = 1'b1;
    do @(posedge clk); while (!cmd.ready);
    words_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      cmd.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = pick_burst();
    end
  endtask

  task automatic send_simple(input kind_t k);
    send_word(k, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_record(input int len);
    int voice_at;
    voice_at = $urandom_range(0, 1) ? $urandom_range(0, len) : -1;
    send_simple(KIND_OPEN);
    for (int j = 0; j <= len; j++) begin
      if (j == voice_at) send_simple(KIND_VOICE);
      if (j < len) send_simple(KIND_APPEND);
    end
    send_simple(KIND_COMMIT);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg.reg_index  = idx;
    cfg.write_data = value;
    cfg.valid      = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  // Registers change only with no command in flight.
  task automatic configure(input logic enable, input logic [31:0] base);
    cmd.valid = 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    write_register(REG_LOG_ENABLE, {31'($urandom), enable});
    write_register(REG_BASE_ADDRESS, base);
    cfg.valid = 1'b0;
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_record(($urandom_range(0, 99) == 0) ? $urandom_range(250, 262)
                                               : $urandom_range(0, 10));
    end else if (r < 62) begin
      repeat ($urandom_range(1, 4)) send_word(KIND_QUERY, 8'($urandom), pick_index(),
                                              8'($urandom));
    end else if (r < 79) begin
      repeat ($urandom_range(1, 4)) send_word(KIND_READ, 8'($urandom), pick_index(),
                                              pick_offset());
    end else if (r < 91) begin
      send_word(kind_t'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (r < 99) begin
      case ($urandom_range(0, 3))
        0: send_simple(KIND_OPEN);
        1: send_simple(KIND_COMMIT);
        2: begin
          send_simple(KIND_OPEN);
          repeat ($urandom_range(0, 4)) send_simple(KIND_APPEND);
          send_simple(KIND_OPEN);
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_simple(KIND_APPEND);
          send_simple(KIND_VOICE);
        end
      endcase
    end else begin
      send_simple(KIND_CLEAR);
    end
  endtask

  // Response side: changing stall patterns, plus one long hold-off while the
  // sender keeps offering words so that the block backs up to its input.
  initial begin : response_side
    int mode;
    int span;
    rsp.ready = 1'b0;
    forever begin
      if (!long_hold_done && words_sent >= 150) begin
        long_hold_done = 1'b1;
        rsp.ready      = 1'b0;
        repeat (400) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (int n = 0; n < span; n++) begin
        case (mode)
          0: rsp.ready = 1'b1;
          1: rsp.ready = $urandom_range(0, 1);
          2: rsp.ready = (n % 4) == 0;
          default: rsp.ready = (n % 8) >= 3;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic        phase_enable [5];
    logic [31:0] phase_base [5];
    int          target;
    phase_enable = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    phase_base   = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom, 32'hFFFF_F800};
    rst             = 1'b1;
    cmd.valid       = 1'b0;
    cmd.kind        = KIND_NOP;
    cmd.data_byte   = '0;
    cmd.entry_index = '0;
    cmd.byte_offset = '0;
    cfg.valid       = 1'b0;
    cfg.reg_index   = REG_LOG_ENABLE;
    cfg.write_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: logging still disabled after reset, empty ring, far indexes.
    send_simple(KIND_OPEN);
    send_simple(KIND_COMMIT);
    send_word(KIND_QUERY, 8'h00, 8'd0, 8'h00);
    send_word(KIND_READ, 8'h00, 8'd255, 8'd255);
    configure(1'b1, 32'h8000_0000);
    send_simple(KIND_OPEN);
    send_word(KIND_APPEND, 8'hFF, 8'h00, 8'h00);
    send_word(KIND_APPEND, 8'h00, 8'h00, 8'h00);
    send_simple(KIND_VOICE);
    send_simple(KIND_OPEN);
    send_simple(KIND_COMMIT);
    send_simple(KIND_COMMIT);
    send_word(KIND_QUERY, 8'h00, 8'd0, 8'h00);
    send_word(KIND_QUERY, 8'h00, 8'd15, 8'h00);
    send_word(KIND_QUERY, 8'h00, 8'd16, 8'h00);
    send_word(KIND_QUERY, 8'h00, 8'd255, 8'h00);
    send_word(KIND_READ, 8'h00, 8'd0, 8'd0);
    send_word(KIND_READ, 8'h00, 8'd0, 8'd2);
    send_word(KIND_READ, 8'h00, 8'd0, 8'd255);
    send_simple(KIND_NOP);
    // With no record open an append still lands in the head slot.
    send_word(KIND_APPEND, 8'hA5, 8'h00, 8'h00);
    send_word(KIND_READ, 8'h00, 8'd1, 8'd0);
    send_simple(KIND_CLEAR);
    send_word(KIND_READ, 8'h00, 8'd1, 8'd0);

    for (int p = 0; p < 5; p++) begin
      configure(phase_enable[p], phase_base[p]);
      target = words_sent + 270;
      // One record is driven past its end to see the overflow.
      if (p == 2 || p == 3) send_record(258);
      while (words_sent < target) random_step();
    end

    cmd.valid = 1'b0;
    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> overwriting_record_ring_buffer.f
design/orb_pkg.sv
design/orb_if.sv
design/orb_ram.sv
design/orb_ctrl.sv
design/orb_dpath.sv
design/overwriting_record_ring_buffer.sv
tb/sv/orb_checker.sv
tb/sv/tb_top.sv
